[hdl/elementary_function_series_unit_defines.svh]
// Assertion macros for the elementary function series unit
`ifndef ELEMENTARY_FUNCTION_SERIES_UNIT_DEFINES_SVH
`define ELEMENTARY_FUNCTION_SERIES_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define EFSU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// next-cycle implication
`define EFSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define EFSU_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define EFSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/efsu_pkg.sv]
// Shared constants, codes and controller/datapath types of the series unit
package efsu_pkg;

   localparam int unsigned MAX_TERMS_DEF = 64;
   localparam int unsigned FRAC_BITS_DEF = 24;
   localparam int unsigned ARG_WIDTH_DEF = 32;

   localparam int unsigned CMD_W       = 3;
   localparam int unsigned TOL_W       = 24;
   localparam int unsigned VALUE_W     = 48;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned TERMS_W     = 7;
   localparam int unsigned TERM_W      = 64;
   localparam int unsigned MUL_DIGIT_W = 16;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16);

   // function codes
   localparam logic [CMD_W-1:0] FN_EXP  = 3'd0;
   localparam logic [CMD_W-1:0] FN_LN   = 3'd1;
   localparam logic [CMD_W-1:0] FN_SIN  = 3'd2;
   localparam logic [CMD_W-1:0] FN_COS  = 3'd3;
   localparam logic [CMD_W-1:0] FN_SINH = 3'd4;
   localparam logic [CMD_W-1:0] FN_COSH = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_CONV   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LIMIT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DOMAIN = 2'd3;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_INIT,
      OP_YDIV,
      OP_Y2,
      OP_MUL1,
      OP_MUL2,
      OP_SMUL,
      OP_DIV1,
      OP_DIV2,
      OP_ACC,
      OP_DBL,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      go;
   } dp_cmd_type;

   typedef struct packed {
      logic invalid;
      logic is_exp;
      logic is_ln;
      logic mul_done;
      logic div_done;
      logic stop;
   } dp_stat_type;

endpackage

[hdl/efsu_mul.sv]
// Iterative 64 x 64 multiplier, one 16-bit digit of the multiplier per cycle
module efsu_mul
   import efsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TERM_W-1:0]     a,
   input  logic [TERM_W-1:0]     b,
   output logic                  done,
   output logic [2*TERM_W-1:0]   product
);

   localparam int unsigned DIGITS = TERM_W / MUL_DIGIT_W;
   localparam int unsigned CNT_W  = $clog2(DIGITS);

   logic [TERM_W-1:0]             a_ff, a_in;
   logic [TERM_W-1:0]             b_ff, b_in;
   logic [2*TERM_W-1:0]           prod_ff, prod_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [TERM_W+MUL_DIGIT_W-1:0] partial;

   // partial product of the top multiplier digit
   always_comb begin
      partial = a_ff * b_ff[TERM_W-1 -: MUL_DIGIT_W];
   end

   // shift-and-add, most significant digit first
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         prod_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         prod_in = {prod_ff[2*TERM_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}}
                   + (2*TERM_W)'(partial);
         b_in    = {b_ff[TERM_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIGITS-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

[hdl/efsu_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle
module efsu_div
   import efsu_pkg::*;
#(
   parameter int unsigned DIVIDEND_W = 64,
   parameter int unsigned DIVISOR_W  = 33
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // one trial subtraction
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/efsu_datapath.sv]
// Series datapath: term, sum and flag registers around a shared multiplier and divider
module efsu_datapath
   import efsu_pkg::*;
#(
   parameter int unsigned MAX_TERMS = MAX_TERMS_DEF,
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
   parameter int unsigned ARG_WIDTH = ARG_WIDTH_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [CMD_W-1:0]           req_command,
   input  logic signed [ARG_WIDTH-1:0] req_argument,
   input  logic [TOL_W-1:0]           tolerance,
   input  dp_cmd_type                 cmd,
   output dp_stat_type                stat,
   output logic                       rsp_strobe,
   output logic signed [VALUE_W-1:0]  rsp_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [TERMS_W-1:0]         rsp_terms_used
);

   localparam int unsigned N_W   = $clog2(MAX_TERMS + 1);
   localparam int unsigned K_W   = N_W + 2;
   localparam int unsigned NUM_W = (ARG_WIDTH > FRAC_BITS + 1) ? ARG_WIDTH : FRAC_BITS + 1;
   localparam int unsigned DIV_W = (NUM_W + FRAC_BITS > TERM_W) ? NUM_W + FRAC_BITS : TERM_W;
   localparam int unsigned DVS_W = NUM_W + 1;

   localparam logic [TERM_W-1:0]        UNIT_ONE  = TERM_W'(1) << FRAC_BITS;
   localparam logic [TERM_W-1:0]        MAG_LIM   = (TERM_W'(1) << 62) - TERM_W'(1);
   localparam logic signed [TERM_W-1:0] OUT_MAX_S = (TERM_W'(1) << (VALUE_W-1)) - TERM_W'(1);
   localparam logic signed [TERM_W-1:0] OUT_MIN_S = -(TERM_W'(1) << (VALUE_W-1));

   // item and series registers
   logic [CMD_W-1:0]           fn_ff, fn_in;
   logic [ARG_WIDTH-1:0]       arg_ff, arg_in;
   logic [TERM_W-1:0]          t_ff, t_in;
   logic                       tneg_ff, tneg_in;
   logic [TERM_W-1:0]          w_ff, w_in;
   logic [TERM_W-1:0]          y2_ff, y2_in;
   logic signed [TERM_W-1:0]   acc_ff, acc_in;
   logic [N_W-1:0]             n_ff, n_in;
   logic                       sat_ff, sat_in;
   logic                       conv_ff, conv_in;
   logic                       strobe_ff, strobe_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   logic [STATUS_W-1:0]        status_ff, status_in;
   logic [TERMS_W-1:0]         terms_ff, terms_in;

   logic                       xneg;
   logic [ARG_WIDTH-1:0]       xmag;
   logic [TERM_W-1:0]          xmag64;
   logic                       odd_fn;
   logic                       alt_fn;
   logic [NUM_W-1:0]           num;
   logic [DVS_W-1:0]           den;
   logic [K_W-1:0]             k;
   logic [K_W-1:0]             k2;
   logic [TERM_W+K_W-1:0]      smul;

   logic                       mul_start;
   logic [TERM_W-1:0]          mul_a;
   logic [TERM_W-1:0]          mul_b;
   logic                       mul_done;
   logic [2*TERM_W-1:0]        product;
   logic [2*TERM_W-1:0]        prod_shift;
   logic                       mul_ovf;
   logic [TERM_W-1:0]          mres;

   logic                       div_start;
   logic [DIV_W-1:0]           dividend;
   logic [DVS_W-1:0]           divisor;
   logic                       div_done;
   logic [DIV_W-1:0]           quotient;

   logic                       new_neg;
   logic                       add_neg;
   logic [TERM_W-1:0]          add_mag;
   logic signed [TERM_W-1:0]   add_sum;
   logic                       add_hi;
   logic                       add_lo;
   logic signed [TERM_W-1:0]   add_res;
   logic [TERM_W-1:0]          init_mag;
   logic                       init_neg;
   logic                       out_hi;
   logic                       out_lo;

   // argument decode
   always_comb begin
      xneg   = arg_ff[ARG_WIDTH-1];
      xmag   = xneg ? (~arg_ff + 1'b1) : arg_ff;
      xmag64 = TERM_W'(xmag);
      odd_fn = (fn_ff == FN_SIN) || (fn_ff == FN_SINH);
      alt_fn = (fn_ff == FN_SIN) || (fn_ff == FN_COS);
      num    = (xmag64 < UNIT_ONE) ? NUM_W'(UNIT_ONE - xmag64) : NUM_W'(xmag64 - UNIT_ONE);
      den    = DVS_W'(xmag64 + UNIT_ONE);
      k      = K_W'(n_ff) + 1'b1;
      k2     = {k[K_W-2:0], 1'b0};
      smul   = w_ff * (k2 - 1'b1);
   end

   // multiplier operands and clamped, rescaled product
   always_comb begin
      mul_start  = cmd.go && ((cmd.op == OP_Y2) || (cmd.op == OP_MUL1) ||
                              (cmd.op == OP_MUL2));
      mul_a      = (cmd.op == OP_MUL2) ? w_ff : t_ff;
      mul_b      = (cmd.op == OP_Y2) ? t_ff : ((fn_ff == FN_LN) ? y2_ff : xmag64);
      prod_shift = product >> FRAC_BITS;
      mul_ovf    = |prod_shift[2*TERM_W-1:62];
      mres       = mul_ovf ? MAG_LIM : prod_shift[TERM_W-1:0];
   end

   // divider operands
   always_comb begin
      div_start = cmd.go && ((cmd.op == OP_YDIV) || (cmd.op == OP_DIV1) ||
                             (cmd.op == OP_DIV2));
      dividend  = DIV_W'(w_ff);
      divisor   = DVS_W'(k);
      case (cmd.op)
         OP_YDIV: begin
            dividend = DIV_W'(num) << FRAC_BITS;
            divisor  = den;
         end
         OP_DIV1: begin
            if (fn_ff == FN_EXP) begin
               divisor = DVS_W'(k);
            end else if ((fn_ff == FN_LN) || odd_fn) begin
               divisor = DVS_W'(k2) + 1'b1;
            end else begin
               divisor = DVS_W'(k2);
            end
         end
         OP_DIV2: begin
            divisor = odd_fn ? DVS_W'(k2) : DVS_W'(k2) - 1'b1;
         end
         default: begin
            divisor = DVS_W'(k);
         end
      endcase
   end

   // signed, clamped accumulate of a sign-magnitude term
   always_comb begin
      if (fn_ff == FN_EXP) begin
         new_neg = tneg_ff ^ xneg;
      end else if (alt_fn) begin
         new_neg = ~tneg_ff;
      end else begin
         new_neg = tneg_ff;
      end
      if (cmd.op == OP_DBL) begin
         add_neg = acc_ff < 0;
         add_mag = add_neg ? TERM_W'(-acc_ff) : TERM_W'(acc_ff);
      end else begin
         add_neg = new_neg;
         add_mag = w_ff;
      end
      add_sum = acc_ff + (add_neg ? -$signed(add_mag) : $signed(add_mag));
      add_hi  = add_sum > $signed(MAG_LIM);
      add_lo  = add_sum < -$signed(MAG_LIM);
      if (add_hi) begin
         add_res = $signed(MAG_LIM);
      end else if (add_lo) begin
         add_res = -$signed(MAG_LIM);
      end else begin
         add_res = add_sum;
      end
      init_neg = odd_fn ? xneg : 1'b0;
      init_mag = odd_fn ? xmag64 : UNIT_ONE;
      out_hi   = acc_ff > OUT_MAX_S;
      out_lo   = acc_ff < OUT_MIN_S;
   end

   // register updates per operation
   always_comb begin
      fn_in     = fn_ff;
      arg_in    = arg_ff;
      t_in      = t_ff;
      tneg_in   = tneg_ff;
      w_in      = w_ff;
      y2_in     = y2_ff;
      acc_in    = acc_ff;
      n_in      = n_ff;
      sat_in    = sat_ff;
      conv_in   = conv_ff;
      strobe_in = 1'b0;
      value_in  = value_ff;
      status_in = status_ff;
      terms_in  = terms_ff;
      case (cmd.op)
         OP_LOAD: begin
            fn_in  = req_command;
            arg_in = req_argument;
         end
         OP_INIT: begin
            sat_in  = 1'b0;
            conv_in = 1'b0;
            n_in    = '0;
            t_in    = init_mag;
            tneg_in = init_neg;
            acc_in  = init_neg ? -$signed(init_mag) : $signed(init_mag);
         end
         OP_YDIV: begin
            if (div_done) begin
               t_in    = quotient[TERM_W-1:0];
               tneg_in = xmag64 < UNIT_ONE;
            end
         end
         OP_Y2: begin
            if (mul_done) begin
               y2_in  = mres;
               sat_in = sat_ff | mul_ovf;
               acc_in = tneg_ff ? -$signed(t_ff) : $signed(t_ff);
            end
         end
         OP_MUL1, OP_MUL2: begin
            if (mul_done) begin
               w_in   = mres;
               sat_in = sat_ff | mul_ovf;
            end
         end
         OP_SMUL: begin
            w_in = smul[TERM_W-1:0];
         end
         OP_DIV1, OP_DIV2: begin
            if (div_done) begin
               w_in = quotient[TERM_W-1:0];
            end
         end
         OP_ACC: begin
            t_in    = w_ff;
            tneg_in = new_neg;
            acc_in  = add_res;
            sat_in  = sat_ff | add_hi | add_lo;
            n_in    = n_ff + 1'b1;
            conv_in = ((fn_ff == FN_EXP) ? w_ff : t_ff) <= TERM_W'(tolerance);
         end
         OP_DBL: begin
            acc_in = add_res;
            sat_in = sat_ff | add_hi | add_lo;
         end
         OP_FINISH: begin
            strobe_in = 1'b1;
            if (stat.invalid) begin
               value_in  = '0;
               status_in = ST_DOMAIN;
               terms_in  = '0;
            end else begin
               if (out_hi) begin
                  value_in = OUT_MAX_S[VALUE_W-1:0];
               end else if (out_lo) begin
                  value_in = OUT_MIN_S[VALUE_W-1:0];
               end else begin
                  value_in = acc_ff[VALUE_W-1:0];
               end
               if (sat_ff || out_hi || out_lo) begin
                  status_in = ST_SAT;
               end else if (conv_ff) begin
                  status_in = ST_CONV;
               end else begin
                  status_in = ST_LIMIT;
               end
               terms_in = TERMS_W'(n_ff);
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      fn_ff     <= fn_in;
      arg_ff    <= arg_in;
      t_ff      <= t_in;
      tneg_ff   <= tneg_in;
      w_ff      <= w_in;
      y2_ff     <= y2_in;
      acc_ff    <= acc_in;
      n_ff      <= n_in;
      sat_ff    <= sat_in;
      conv_ff   <= conv_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      terms_ff  <= terms_in;
   end

   efsu_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (product)
   );

   efsu_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // status back to the controller
   always_comb begin
      stat.invalid  = (fn_ff > FN_COSH) || ((fn_ff == FN_LN) && xneg);
      stat.is_exp   = fn_ff == FN_EXP;
      stat.is_ln    = fn_ff == FN_LN;
      stat.mul_done = mul_done;
      stat.div_done = div_done;
      stat.stop     = conv_ff || (n_ff == N_W'(MAX_TERMS));
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_value      = value_ff;
   assign rsp_status     = status_ff;
   assign rsp_terms_used = terms_ff;

endmodule

[hdl/efsu_ctrl.sv]
// Controller state machine sequencing the series datapath
module efsu_ctrl
   import efsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_CHECK = 13'b0000000000010,
      S_YDIV  = 13'b0000000000100,
      S_Y2    = 13'b0000000001000,
      S_MUL1  = 13'b0000000010000,
      S_MUL2  = 13'b0000000100000,
      S_SMUL  = 13'b0000001000000,
      S_DIV1  = 13'b0000010000000,
      S_DIV2  = 13'b0000100000000,
      S_ACC   = 13'b0001000000000,
      S_TEST  = 13'b0010000000000,
      S_DBL   = 13'b0100000000000,
      S_OUT   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      started_ff, started_in;
   logic      unit_done;

   // next state and datapath command
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NOP;
      cmd.go    = 1'b0;
      unit_done = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.op = OP_INIT;
            if (stat.invalid) begin
               state_in = S_OUT;
            end else if (stat.is_ln) begin
               state_in = S_YDIV;
            end else begin
               state_in = S_MUL1;
            end
         end
         S_YDIV: begin
            cmd.op    = OP_YDIV;
            cmd.go    = ~started_ff;
            unit_done = stat.div_done;
            if (stat.div_done) begin
               state_in = S_Y2;
            end
         end
         S_Y2: begin
            cmd.op    = OP_Y2;
            cmd.go    = ~started_ff;
            unit_done = stat.mul_done;
            if (stat.mul_done) begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.op    = OP_MUL1;
            cmd.go    = ~started_ff;
            unit_done = stat.mul_done;
            if (stat.mul_done) begin
               if (stat.is_exp) begin
                  state_in = S_DIV1;
               end else if (stat.is_ln) begin
                  state_in = S_SMUL;
               end else begin
                  state_in = S_MUL2;
               end
            end
         end
         S_MUL2: begin
            cmd.op    = OP_MUL2;
            cmd.go    = ~started_ff;
            unit_done = stat.mul_done;
            if (stat.mul_done) begin
               state_in = S_DIV1;
            end
         end
         S_SMUL: begin
            cmd.op   = OP_SMUL;
            state_in = S_DIV1;
         end
         S_DIV1: begin
            cmd.op    = OP_DIV1;
            cmd.go    = ~started_ff;
            unit_done = stat.div_done;
            if (stat.div_done) begin
               state_in = (stat.is_exp || stat.is_ln) ? S_ACC : S_DIV2;
            end
         end
         S_DIV2: begin
            cmd.op    = OP_DIV2;
            cmd.go    = ~started_ff;
            unit_done = stat.div_done;
            if (stat.div_done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.op   = OP_ACC;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (stat.stop) begin
               state_in = stat.is_ln ? S_DBL : S_OUT;
            end else begin
               state_in = S_MUL1;
            end
         end
         S_DBL: begin
            cmd.op   = OP_DBL;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.op   = OP_FINISH;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // a unit is started once per wait state
   always_comb begin
      started_in = started_ff;
      if (unit_done) begin
         started_in = 1'b0;
      end else if (cmd.go) begin
         started_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

[hdl/elementary_function_series_unit.sv]
// A rejected transaction goes straight to the result. Each sin/cos/sinh/cosh term takes two
// multiplies and two divides, an exp term one of each, an ln term a multiply, a scaling and a
// divide; ln also divides and squares once first and doubles the sum last. A multiply is 4 steps.
// Throughput: one transaction at a time; busy is high from acceptance until the result.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset is synchronous: the controller returns to idle and tolerance reloads to 16.
`include "elementary_function_series_unit_defines.svh"

module elementary_function_series_unit
   import efsu_pkg::*;
#(
   parameter int unsigned MAX_TERMS = MAX_TERMS_DEF,
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
   parameter int unsigned ARG_WIDTH = ARG_WIDTH_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [CMD_W-1:0]            req_command,
   input  logic signed [ARG_WIDTH-1:0] req_argument,
   output logic                        rsp_strobe,
   output logic signed [VALUE_W-1:0]   rsp_value,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [TERMS_W-1:0]          rsp_terms_used,
   input  logic                        csr_write_enable,
   input  logic [TOL_W-1:0]            csr_write_data
);

   logic [TOL_W-1:0] tolerance_ff, tolerance_in;
   dp_cmd_type       cmd;
   dp_stat_type      stat;

   // tolerance register
   always_comb begin
      tolerance_in = csr_write_enable ? csr_write_data : tolerance_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOL_RESET;
      end else begin
         tolerance_ff <= tolerance_in;
      end
   end

   efsu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   efsu_datapath #(
      .MAX_TERMS (MAX_TERMS),
      .FRAC_BITS (FRAC_BITS),
      .ARG_WIDTH (ARG_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_argument   (req_argument),
      .tolerance      (tolerance_ff),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_strobe     (rsp_strobe),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_terms_used (rsp_terms_used)
   );

   // checks
   `EFSU_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `EFSU_ASSERT_IMPLIES(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy))
   `EFSU_ASSERT_IMPLIES(a_domain_zero, clock, reset, rsp_strobe && (rsp_status == ST_DOMAIN), (rsp_value == '0) && (rsp_terms_used == '0))

endmodule

[test/elementary_function_series_unit_test.sv]
// Self-checking testbench of the elementary function series unit
`timescale 1ns / 100ps

module elementary_function_series_unit_test;
   import efsu_pkg::*;

   localparam int unsigned   FRAC         = FRAC_BITS_DEF;
   localparam bit [63:0]     UNIT_ONE     = 64'd1 << FRAC;
   localparam bit [63:0]     MAG_LIM      = (64'd1 << 62) - 64'd1;
   localparam longint        OUT_MAX      = (longint'(1) << 47) - 1;
   localparam longint        OUT_MIN      = -(longint'(1) << 47);
   localparam int unsigned   MAX_TERMS    = MAX_TERMS_DEF;
   localparam longint        CYCLE_LIMIT  = 40_000_000;
   localparam int unsigned   RANDOM_ITEMS = 1130;

   typedef struct {
      logic [CMD_W-1:0] fn;
      logic [31:0]      arg;
      int unsigned      gap;
   } series_request_type;

   typedef struct {
      logic [CMD_W-1:0]    fn;
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
      logic [TERMS_W-1:0]  terms;
   } series_result_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [CMD_W-1:0]          req_command;
   logic signed [31:0]        req_argument;
   logic                      rsp_strobe;
   logic signed [VALUE_W-1:0] rsp_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic [TERMS_W-1:0]        rsp_terms_used;
   logic                      csr_write_enable;
   logic [TOL_W-1:0]          csr_write_data;

   series_request_type pending_requests[$];
   series_result_type  expected_results[$];
   logic [TOL_W-1:0] tolerance_shadow;
   bit               sat_seen;
   int unsigned      gap_count;
   int unsigned      error_count;
   int unsigned      accepted_count;
   int unsigned      result_count;
   int unsigned      status_count[4];
   longint           cycle_count;

   elementary_function_series_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_argument     (req_argument),
      .rsp_strobe       (rsp_strobe),
      .rsp_value        (rsp_value),
      .rsp_status       (rsp_status),
      .rsp_terms_used   (rsp_terms_used),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // exact product scaled down by the fraction bits, clamped to the internal limit
   function automatic bit [63:0] scaled_product(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> FRAC;
      if (p > {64'd0, MAG_LIM}) begin
         sat_seen = 1'b1;
         return MAG_LIM;
      end
      return p[63:0];
   endfunction

   // signed running sum, clamped to the internal limit
   function automatic void add_term(inout longint sum, input bit neg, input bit [63:0] mag);
      longint s;
      s = sum + (neg ? -longint'(mag) : longint'(mag));
      if (s > longint'(MAG_LIM)) begin
         s = longint'(MAG_LIM);
         sat_seen = 1'b1;
      end
      if (s < -longint'(MAG_LIM)) begin
         s = -longint'(MAG_LIM);
         sat_seen = 1'b1;
      end
      sum = s;
   endfunction

   // series sum as the unit should produce it
   function automatic series_result_type sum_series(logic [CMD_W-1:0] fn, logic [31:0] arg,
                                                    logic [TOL_W-1:0] tol);
      series_result_type r;
      bit        xneg, tneg, conv;
      bit [31:0] neg_arg;
      bit [63:0] xmag, t, prev, y2, k, num, den;
      longint    sum;
      int unsigned n;
      r.fn = fn;
      r.value = '0;
      r.status = ST_DOMAIN;
      r.terms = '0;
      sat_seen = 1'b0;
      conv = 1'b0;
      n = 0;
      y2 = 0;
      xneg = arg[31];
      neg_arg = -arg;
      xmag = xneg ? {32'd0, neg_arg} : {32'd0, arg};
      if (fn > FN_COSH || (fn == FN_LN && xneg))
         return r;
      if (fn == FN_LN) begin
         // y = (x-1)/(x+1), magnitude with fraction bits
         den = xmag + UNIT_ONE;
         tneg = xmag < UNIT_ONE;
         num = tneg ? UNIT_ONE - xmag : xmag - UNIT_ONE;
         t = (num << FRAC) / den;
         y2 = scaled_product(t, t);
      end else if (fn == FN_SIN || fn == FN_SINH) begin
         t = xmag;
         tneg = xneg;
      end else begin
         t = UNIT_ONE;
         tneg = 1'b0;
      end
      sum = tneg ? -longint'(t) : longint'(t);
      while (n < MAX_TERMS) begin
         prev = t;
         k = n + 1;
         if (fn == FN_EXP) begin
            t = scaled_product(t, xmag) / k;
            tneg = tneg ^ xneg;
         end else if (fn == FN_LN) begin
            t = scaled_product(t, y2);
            t = t * (2 * k - 1) / (2 * k + 1);   // wraps at 64 bits like the unit
         end else begin
            t = scaled_product(t, xmag);
            t = scaled_product(t, xmag);
            if (fn == FN_SIN || fn == FN_SINH)
               t = t / (2 * k + 1) / (2 * k);
            else
               t = t / (2 * k) / (2 * k - 1);
            if (fn == FN_SIN || fn == FN_COS)
               tneg = !tneg;
         end
         add_term(sum, tneg, t);
         n++;
         if ((fn == FN_EXP ? t : prev) <= {40'd0, tol}) begin
            conv = 1'b1;
            break;
         end
      end
      if (fn == FN_LN)
         add_term(sum, sum < 0, sum < 0 ? 64'(-sum) : 64'(sum));
      if (sum > OUT_MAX) begin
         sum = OUT_MAX;
         sat_seen = 1'b1;
      end
      if (sum < OUT_MIN) begin
         sum = OUT_MIN;
         sat_seen = 1'b1;
      end
      r.value = sum[VALUE_W-1:0];
      r.status = sat_seen ? ST_SAT : (conv ? ST_CONV : ST_LIMIT);
      r.terms = n[TERMS_W-1:0];
      return r;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // driver: one transaction per accepted start
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_count <= 0;
      end else if (start && !busy) begin
         expected_results.push_back(sum_series(req_command, req_argument, tolerance_shadow));
         accepted_count <= accepted_count + 1;
         void'(pending_requests.pop_front());
         if (pending_requests.size() > 0 && pending_requests[0].gap == 0) begin
            req_command <= pending_requests[0].fn;
            req_argument <= pending_requests[0].arg;
         end else begin
            start <= 1'b0;
         end
         gap_count <= 0;
      end else if (!start && pending_requests.size() > 0) begin
         if (gap_count < pending_requests[0].gap) begin
            gap_count <= gap_count + 1;
         end else begin
            req_command <= pending_requests[0].fn;
            req_argument <= pending_requests[0].arg;
            start <= 1'b1;
            gap_count <= 0;
         end
      end
   end

   // monitor: compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      series_result_type want;
      if (!reset && rsp_strobe) begin
         result_count <= result_count + 1;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result value=%h status=%0d terms=%0d", $time,
                     rsp_value, rsp_status, rsp_terms_used);
            error_count <= error_count + 1;
         end else begin
            want = expected_results.pop_front();
            status_count[want.status] <= status_count[want.status] + 1;
            if (rsp_value !== want.value || rsp_status !== want.status ||
                rsp_terms_used !== want.terms) begin
               $display("%0t: fn %0d expected value=%h status=%0d terms=%0d, got value=%h status=%0d terms=%0d",
                        $time, want.fn, want.value, want.status, want.terms,
                        rsp_value, rsp_status, rsp_terms_used);
               error_count <= error_count + 1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic queue_request(logic [CMD_W-1:0] fn, logic [31:0] arg, bit no_gaps);
      series_request_type q;
      q.fn = fn;
      q.arg = arg;
      q.gap = no_gaps ? 0 : $urandom_range(0, 10);
      pending_requests.push_back(q);
   endtask

   // wait until every transaction has returned, then set tolerance
   task automatic set_tolerance(logic [TOL_W-1:0] tol);
      while (pending_requests.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_data <= tol;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tolerance_shadow = tol;
   endtask

   // random argument: mostly small magnitudes, now and then any 32-bit pattern
   function automatic logic [31:0] draw_argument(logic [CMD_W-1:0] fn);
      logic [31:0] a;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         a = $urandom;
      else if (pick < 20)
         a = $urandom_range(0, 32'h0400_0000);        // up to 4.0
      else
         a = $urandom_range(0, 32'h0200_0000);        // up to 2.0
      if (fn != FN_LN && $urandom_range(0, 1))
         a = -a;
      else if (fn == FN_LN && pick >= 5 && $urandom_range(0, 19) == 0)
         a = -a;                                      // domain error now and then
      return a;
   endfunction

   task automatic queue_random(int unsigned count);
      logic [CMD_W-1:0] fn;
      bit no_gaps;
      no_gaps = 1'b0;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 40 == 0)
            no_gaps = ($urandom_range(0, 3) == 0);
         fn = ($urandom_range(0, 49) == 0) ? CMD_W'($urandom_range(6, 7))
                                           : CMD_W'($urandom_range(0, 5));
         queue_request(fn, draw_argument(fn), no_gaps);
      end
   endtask

   // stimulus
   initial begin
      logic [CMD_W-1:0] fn;
      reset = 1'b1;
      start = 1'b0;
      req_command = FN_EXP;
      req_argument = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      tolerance_shadow = TOL_RESET;
      error_count = 0;
      accepted_count = 0;
      result_count = 0;
      cycle_count = 0;
      for (int i = 0; i < 4; i++)
         status_count[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, one and minus one per function, plus argument extremes for some functions
      for (int f = 0; f <= 5; f++) begin
         fn = CMD_W'(f);
         queue_request(fn, 32'h0000_0000, 1'b0);
         queue_request(fn, 32'h0100_0000, 1'b0);
         queue_request(fn, 32'hFF00_0000, 1'b1);
         if (fn == FN_EXP || fn == FN_SIN)
            queue_request(fn, 32'h7FFF_FFFF, 1'b0);
         if (fn == FN_COSH)
            queue_request(fn, 32'h8000_0000, 1'b0);
      end
      queue_request(FN_LN, 32'h7FFF_FFFF, 1'b0);
      queue_request(3'd6, 32'h0100_0000, 1'b0);
      queue_request(3'd7, 32'h0000_0000, 1'b1);

      // random phases under several tolerance settings
      queue_random(RANDOM_ITEMS / 5);
      set_tolerance(24'd0);
      queue_random(RANDOM_ITEMS / 5);
      set_tolerance(24'hFF_FFFF);
      queue_random(RANDOM_ITEMS / 5);
      set_tolerance(TOL_W'($urandom_range(1, 4096)));
      queue_random(RANDOM_ITEMS / 5);
      set_tolerance(TOL_W'($urandom));
      queue_random(RANDOM_ITEMS / 5);

      while (pending_requests.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Run covered %0d transactions over all functions and five tolerance settings;",
               accepted_count);
      $display("results: %0d converged, %0d term limit, %0d saturated, %0d domain/unknown.",
               status_count[ST_CONV], status_count[ST_LIMIT], status_count[ST_SAT],
               status_count[ST_DOMAIN]);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
